@@ hdl/pln_pkg.sv @@
// shared types, constants and the restoring division step for the paged list navigator
// no dependencies
package pln_pkg;

  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned DIV_STAGES = INDEX_BITS;
  localparam int unsigned PROD_BITS  = 2 * INDEX_BITS;
  localparam int unsigned SUM_BITS   = PROD_BITS + 1;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [PROD_BITS-1:0]  prod_t;
  typedef logic [SUM_BITS-1:0]   sum_t;

  typedef enum logic [1:0] {
    KIND_NEXT_ITEM = 2'd0,
    KIND_PREV_ITEM = 2'd1,
    KIND_NEXT_PAGE = 2'd2,
    KIND_PREV_PAGE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    idx_t  current_index;
    idx_t  total_items;
    idx_t  items_per_page;
  } pln_in_t;

  typedef struct packed {
    idx_t new_index;
    logic has_next_page;
    logic has_previous_page;
  } pln_out_t;

  // partial remainder plus dividend bits that turn into quotient bits
  typedef struct packed {
    idx_t rem;
    idx_t dq;
  } div_lane_t;

  typedef struct packed {
    pln_in_t   req;
    div_lane_t by_total;
    div_lane_t by_page;
    div_lane_t last_page;
  } pln_div_t;

  typedef struct packed {
    kind_t kind;
    idx_t  cur;
    idx_t  total;
    idx_t  per;
    idx_t  row;
    idx_t  item_idx;
    prod_t prod;
    logic  has_next;
    logic  has_prev;
    logic  degenerate;
    logic  one_page;
  } pln_mid_t;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic div_lane_t div_step(div_lane_t lane, idx_t divisor);
    logic [INDEX_BITS:0] trial;
    logic                qbit;
    div_lane_t           res;
    trial = {lane.rem, lane.dq[INDEX_BITS-1]};
    qbit  = 1'b0;
    if (trial >= {1'b0, divisor}) begin
      trial = trial - {1'b0, divisor};
      qbit  = 1'b1;
    end
    res.rem = trial[INDEX_BITS-1:0];
    res.dq  = {lane.dq[INDEX_BITS-2:0], qbit};
    return res;
  endfunction

endpackage

@@ hdl/pln_div_stage.sv @@
// one quotient bit of the three parallel divisions, registered with a valid bit
// depends on pln_pkg
module pln_div_stage import pln_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  input  pln_div_t up_data,
  output logic     up_ready,
  output logic     dn_valid,
  output pln_div_t dn_data,
  input  logic     dn_ready
);

  logic     valid_r;
  pln_div_t data_r, data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt           = up_data;
    data_nxt.by_total  = div_step(up_data.by_total, up_data.req.total_items);
    data_nxt.by_page   = div_step(up_data.by_page, up_data.req.items_per_page);
    data_nxt.last_page = div_step(up_data.last_page, up_data.req.items_per_page);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ hdl/pln_mul_stage.sv @@
// item step results, flags, target page and target page times page size
// depends on pln_pkg
module pln_mul_stage import pln_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  input  pln_div_t up_data,
  output logic     up_ready,
  output logic     dn_valid,
  output pln_mid_t dn_data,
  input  logic     dn_ready
);

  logic                valid_r;
  pln_mid_t            data_r, data_nxt;
  idx_t                cur_page, last_page, rem_tot, total, per, tgt, nxt_item, prv_item;
  logic [INDEX_BITS:0] rem_inc;
  logic                flags_ok;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    total     = up_data.req.total_items;
    per       = up_data.req.items_per_page;
    cur_page  = up_data.by_page.dq;
    last_page = up_data.last_page.dq;
    rem_tot   = up_data.by_total.rem;
    rem_inc   = {1'b0, rem_tot} + {{INDEX_BITS{1'b0}}, 1'b1};
    nxt_item  = (rem_inc == {1'b0, total}) ? '0 : rem_inc[INDEX_BITS-1:0];
    prv_item  = (rem_tot == '0) ? (total - idx_t'(1)) : (rem_tot - idx_t'(1));
    if (up_data.req.kind == KIND_NEXT_PAGE) begin
      tgt = (cur_page < last_page) ? (cur_page + idx_t'(1)) : cur_page;
    end else begin
      tgt = (cur_page != '0) ? (cur_page - idx_t'(1)) : cur_page;
    end
    flags_ok = (total != '0) && (per != '0) && (total > per);

    data_nxt.kind  = up_data.req.kind;
    data_nxt.cur   = up_data.req.current_index;
    data_nxt.total = total;
    data_nxt.per   = per;
    data_nxt.row   = up_data.by_page.rem;
    unique case (up_data.req.kind)
      KIND_NEXT_ITEM: data_nxt.item_idx = (total == '0) ? '0 : nxt_item;
      KIND_PREV_ITEM: data_nxt.item_idx = (total == '0) ? '0 : prv_item;
      default:        data_nxt.item_idx = '0;
    endcase
    data_nxt.prod       = {{INDEX_BITS{1'b0}}, tgt} * {{INDEX_BITS{1'b0}}, per};
    data_nxt.has_next   = flags_ok && (cur_page < last_page);
    data_nxt.has_prev   = flags_ok && (cur_page != '0);
    data_nxt.degenerate = (total == '0) || (per == '0);
    data_nxt.one_page   = (total <= per);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ hdl/pln_out_stage.sv @@
// page step clamp, final selection and the output register
// depends on pln_pkg
module pln_out_stage import pln_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  input  pln_mid_t up_data,
  output logic     up_ready,
  output logic     out_valid,
  output pln_out_t out_data,
  input  logic     out_stall
);

  logic     valid_r;
  pln_out_t data_r, data_nxt;
  sum_t     cand, lim_total, lim_page, lim, page_idx;

  assign up_ready  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    cand      = {1'b0, up_data.prod} + sum_t'(up_data.row);
    lim_total = sum_t'(up_data.total) - sum_t'(1);
    lim_page  = {1'b0, up_data.prod} + sum_t'(up_data.per) - sum_t'(1);
    lim       = (lim_total < lim_page) ? lim_total : lim_page;
    page_idx  = (cand < lim) ? cand : lim;

    data_nxt.has_next_page     = up_data.has_next;
    data_nxt.has_previous_page = up_data.has_prev;
    priority if (up_data.kind == KIND_NEXT_ITEM || up_data.kind == KIND_PREV_ITEM) begin
      data_nxt.new_index = up_data.item_idx;
    end else if (up_data.degenerate) begin
      data_nxt.new_index = '0;
    end else if (up_data.one_page) begin
      data_nxt.new_index = up_data.cur;
    end else begin
      data_nxt.new_index = page_idx[INDEX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ hdl/paged_list_index_navigator.sv @@
// top level of the paged list navigator: division pipeline, multiply stage, output stage
// depends on pln_pkg, pln_div_stage, pln_mul_stage, pln_out_stage
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | pln_in_t  (kind, index, length, page size)
//   out     | output    | out_valid/out_stall | pln_out_t (new index, page flags)
//
// the pipeline has a division stage per quotient bit, then a multiply stage, then
// the clamp and output register
// one item is taken every cycle unless in_stall is raised; three restoring dividers run side by side
// reset clears every stage valid bit, payload registers are not reset
// each stage refills as soon as its successor has room, so a stalled output
// lets bubbles behind it close up; in_stall rises only when every stage is full
module paged_list_index_navigator import pln_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  pln_in_t  in_data,
  output logic     in_stall,
  output logic     out_valid,
  output pln_out_t out_data,
  input  logic     out_stall
);

  // division chain: index 0 is the entry, DIV_STAGES is the last stage output
  logic     div_v   [DIV_STAGES+1];
  pln_div_t div_d   [DIV_STAGES+1];
  logic     div_rdy [DIV_STAGES+1];

  logic     mid_v;
  pln_mid_t mid_d;
  logic     mid_rdy;

  // seed the three divisions: index over length, index over page size,
  // and last item over page size for the last page number
  always_comb begin
    div_d[0].req           = in_data;
    div_d[0].by_total.rem  = '0;
    div_d[0].by_total.dq   = in_data.current_index;
    div_d[0].by_page.rem   = '0;
    div_d[0].by_page.dq    = in_data.current_index;
    div_d[0].last_page.rem = '0;
    div_d[0].last_page.dq  = in_data.total_items - idx_t'(1);
  end

  assign div_v[0] = in_valid;
  assign in_stall = !div_rdy[0];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    pln_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (div_v[g]),
      .up_data  (div_d[g]),
      .up_ready (div_rdy[g]),
      .dn_valid (div_v[g+1]),
      .dn_data  (div_d[g+1]),
      .dn_ready (div_rdy[g+1])
    );
  end

  // target page and its first index
  pln_mul_stage u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (div_v[DIV_STAGES]),
    .up_data  (div_d[DIV_STAGES]),
    .up_ready (div_rdy[DIV_STAGES]),
    .dn_valid (mid_v),
    .dn_data  (mid_d),
    .dn_ready (mid_rdy)
  );

  // clamp within the page and the list, pick the result per kind
  pln_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (mid_v),
    .up_data   (mid_d),
    .up_ready  (mid_rdy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

@@ hdl/pln_checker.sv @@
// port level checks for the paged list navigator, bound to the top level
// depends on pln_pkg and paged_list_index_navigator
module pln_checker import pln_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input pln_in_t  in_data,
  input logic     in_stall,
  input logic     out_valid,
  input pln_out_t out_data,
  input logic     out_stall
);

  // pipeline empties on reset
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

  // input back-pressure only when the output is full and held
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output item dropped");

  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled output item changed");

endmodule

bind paged_list_index_navigator pln_checker u_pln_checker (.*);
